[src/pcs_pkg.sv]
// Package for the percentile contrast stretch unit.
// Holds shared constants, types and the operation codes; no dependencies.
package pcs_pkg;

  localparam int unsigned CountBitsDef = 22;
  localparam int unsigned Bins = 256;
  localparam int unsigned PctW = 7;
  localparam int unsigned PixW = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_PCT  = 1'b0,
    CFG_HIGH_PCT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_HIST    = 1'b0,
    OP_STRETCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_RMW,
    ST_WALK_RD,
    ST_WALK,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    logic            op;
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
    logic            fe;
  } item_t;

endpackage

[src/pcs_queue.sv]
// Two-entry queue between the front and the back of the unit.
// Depends on pcs_pkg for the item type.
module pcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcs_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pcs_pkg::item_t data_o
);
  import pcs_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

[src/pcs_back.sv]
// Back part: histogram memories, end point walk and the stretch divider.
// Depends on pcs_pkg for types and constants.
module pcs_back #(
  parameter int unsigned CountBits = pcs_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pcs_pkg::PctW-1:0] low_pct_i,
  input  logic [pcs_pkg::PctW-1:0] high_pct_i,
  input  logic                     q_empty_i,
  input  pcs_pkg::item_t           q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [pcs_pkg::PixW-1:0] red_o,
  output logic [pcs_pkg::PixW-1:0] green_o,
  output logic [pcs_pkg::PixW-1:0] blue_o,
  output logic                     clearing_o
);
  import pcs_pkg::*;

  localparam int unsigned BinW = $clog2(Bins);
  localparam int unsigned CumW = CountBits + BinW;
  localparam int unsigned ProdW = CumW + PctW;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam int unsigned NumW = 17;
  localparam int unsigned DivSteps = 16;

  back_state_e state_q, state_d;

  logic [CountBits-1:0] hist_mem [3][Bins];
  logic [CountBits-1:0] rd_data_q [3];
  logic [BinW-1:0]      rd_addr [3];
  logic                 wr_en;
  logic [BinW-1:0]      wr_addr [3];
  logic [CountBits-1:0] wr_data [3];

  logic [BinW-1:0]      clr_q, clr_d;
  logic                 clr_busy_q, clr_busy_d;
  item_t                cur_q, cur_d;
  logic [CountBits-1:0] total_q, total_d;
  logic [BinW-1:0]      lo_pt_q [3], lo_pt_d [3];
  logic [BinW-1:0]      hi_pt_q [3], hi_pt_d [3];
  logic [BinW-1:0]      walk_q, walk_d;
  logic [CumW-1:0]      cum_q [3], cum_d [3];
  logic                 lo_f_q [3], lo_f_d [3];
  logic                 hi_f_q [3], hi_f_d [3];
  logic [ProdW-1:0]     need_lo_q, need_lo_d, need_hi_q, need_hi_d;

  logic [4:0]           div_cnt_q, div_cnt_d;
  logic [NumW-1:0]      num_q [3], num_d [3];
  logic [BinW-1:0]      den_q [3], den_d [3];
  logic [BinW:0]        rem_q [3], rem_d [3];
  logic [2:0]           mode_q, mode_d;
  logic [PixW-1:0]      outv_q [3], outv_d [3];
  logic                 ov_q, ov_d;

  logic                 out_free;
  assign out_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      rd_data_q[c] <= hist_mem[c][rd_addr[c]];
      if (wr_en) hist_mem[c][wr_addr[c]] <= wr_data[c];
    end
  end

  always_comb begin
    logic [CumW-1:0]    nc;
    logic [ProdW-1:0]   m;
    logic [PixW:0]      dv;
    logic [NumW-1:0]    nn;
    state_d = state_q;
    clr_d = clr_q;
    clr_busy_d = clr_busy_q;
    cur_d = cur_q;
    total_d = total_q;
    walk_d = walk_q;
    need_lo_d = need_lo_q;
    need_hi_d = need_hi_q;
    div_cnt_d = div_cnt_q;
    mode_d = mode_q;
    ov_d = ov_q;
    q_pop_o = 1'b0;
    wr_en = 1'b0;
    nc = '0;
    m = '0;
    dv = '0;
    nn = '0;
    for (int c = 0; c < 3; c++) begin
      lo_pt_d[c] = lo_pt_q[c];
      hi_pt_d[c] = hi_pt_q[c];
      cum_d[c] = cum_q[c];
      lo_f_d[c] = lo_f_q[c];
      hi_f_d[c] = hi_f_q[c];
      num_d[c] = num_q[c];
      den_d[c] = den_q[c];
      rem_d[c] = rem_q[c];
      outv_d[c] = outv_q[c];
      wr_addr[c] = cur_q.op == OP_HIST ?
                   (c == 0 ? cur_q.r : c == 1 ? cur_q.g : cur_q.b) : clr_q;
      rd_addr[c] = walk_q;
      wr_data[c] = '0;
    end
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (clr_busy_q) begin
      wr_en = 1'b1;
      for (int c = 0; c < 3; c++) wr_addr[c] = clr_q;
      clr_d = clr_q + 1'b1;
      if (clr_q == BinW'(Bins - 1)) clr_busy_d = 1'b0;
    end else begin
      case (state_q)
        ST_RUN: begin
          rd_addr[0] = q_data_i.r;
          rd_addr[1] = q_data_i.g;
          rd_addr[2] = q_data_i.b;
          if (!q_empty_i) begin
            if (q_data_i.op == OP_HIST) begin
              q_pop_o = 1'b1;
              cur_d = q_data_i;
              state_d = ST_RMW;
            end else if (out_free) begin
              q_pop_o = 1'b1;
              cur_d = q_data_i;
              for (int c = 0; c < 3; c++) begin
                dv = c == 0 ? {1'b0, q_data_i.r} : c == 1 ? {1'b0, q_data_i.g}
                                                          : {1'b0, q_data_i.b};
                if (hi_pt_q[c] == lo_pt_q[c]) begin
                  mode_d[c] = 1'b1;
                  outv_d[c] = dv[PixW-1:0];
                end else if (dv <= {1'b0, lo_pt_q[c]} ||
                             hi_pt_q[c] < lo_pt_q[c]) begin
                  // Zero or negative quotient clamps to zero; a negative
                  // range with a lower value gives a quotient that is
                  // handled below.
                  mode_d[c] = 1'b1;
                  outv_d[c] = '0;
                  if (hi_pt_q[c] < lo_pt_q[c] && dv < {1'b0, hi_pt_q[c]}) begin
                    mode_d[c] = 1'b0;
                    num_d[c] = NumW'(({1'b0, lo_pt_q[c]} - dv) * 9'd255);
                    den_d[c] = lo_pt_q[c] - hi_pt_q[c];
                  end else if (hi_pt_q[c] < lo_pt_q[c] &&
                               dv < {1'b0, lo_pt_q[c]}) begin
                    mode_d[c] = 1'b0;
                    num_d[c] = NumW'(({1'b0, lo_pt_q[c]} - dv) * 9'd255);
                    den_d[c] = lo_pt_q[c] - hi_pt_q[c];
                  end
                end else begin
                  mode_d[c] = 1'b0;
                  num_d[c] = NumW'((dv - {1'b0, lo_pt_q[c]}) * 9'd255);
                  den_d[c] = hi_pt_q[c] - lo_pt_q[c];
                end
                rem_d[c] = '0;
              end
              div_cnt_d = '0;
              state_d = ST_DIV;
            end
          end
        end
        ST_RMW: begin
          wr_en = 1'b1;
          for (int c = 0; c < 3; c++) begin
            wr_data[c] = rd_data_q[c] == CountMax ? CountMax : rd_data_q[c] + 1'b1;
          end
          total_d = total_q == CountMax ? CountMax : total_q + 1'b1;
          state_d = ST_RUN;
          if (cur_q.fe) begin
            walk_d = '0;
            state_d = ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          // The last write is already in the bin memories; the read of the first bin is issued here.
          need_lo_d = ProdW'(low_pct_i * total_q);
          need_hi_d = ProdW'(high_pct_i * total_q);
          for (int c = 0; c < 3; c++) begin
            cum_d[c] = '0;
            lo_f_d[c] = 1'b0;
            hi_f_d[c] = 1'b0;
            lo_pt_d[c] = BinW'(Bins - 1);
            hi_pt_d[c] = BinW'(Bins - 1);
          end
          state_d = ST_WALK;
          walk_d = walk_q + 1'b1;
          rd_addr[0] = walk_q;
        end
        ST_WALK: begin
          for (int c = 0; c < 3; c++) begin
            nc = cum_q[c] + CumW'(rd_data_q[c]);
            cum_d[c] = nc;
            m = ProdW'(nc * 7'd100);
            if (!lo_f_q[c] && m >= need_lo_q) begin
              lo_f_d[c] = 1'b1;
              lo_pt_d[c] = walk_q - 1'b1;
            end
            if (!hi_f_q[c] && m >= need_hi_q) begin
              hi_f_d[c] = 1'b1;
              hi_pt_d[c] = walk_q - 1'b1;
            end
          end
          walk_d = walk_q + 1'b1;
          if (walk_q == '0) begin
            total_d = '0;
            clr_d = '0;
            clr_busy_d = 1'b1;
            state_d = ST_RUN;
          end
        end
        ST_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (!mode_q[c]) begin
              nn = num_q[c];
              dv = {rem_q[c][PixW-1:0], nn[NumW-1]};
              if (dv >= {1'b0, den_q[c]}) begin
                rem_d[c] = dv - {1'b0, den_q[c]};
                num_d[c] = {nn[NumW-2:0], 1'b1};
              end else begin
                rem_d[c] = dv;
                num_d[c] = {nn[NumW-2:0], 1'b0};
              end
            end
          end
          div_cnt_d = div_cnt_q + 1'b1;
          if (div_cnt_q == 5'(DivSteps)) begin
            for (int c = 0; c < 3; c++) begin
              if (!mode_q[c]) begin
                outv_d[c] = num_d[c][NumW-1:PixW] != '0 ? 8'hFF : num_d[c][PixW-1:0];
              end
            end
            ov_d = 1'b1;
            state_d = ST_RUN;
          end
        end
        default: state_d = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    walk_q <= walk_d;
    need_lo_q <= need_lo_d;
    need_hi_q <= need_hi_d;
    div_cnt_q <= div_cnt_d;
    mode_q <= mode_d;
    for (int c = 0; c < 3; c++) begin
      cum_q[c] <= cum_d[c];
      lo_f_q[c] <= lo_f_d[c];
      hi_f_q[c] <= hi_f_d[c];
      num_q[c] <= num_d[c];
      den_q[c] <= den_d[c];
      rem_q[c] <= rem_d[c];
      outv_q[c] <= outv_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      clr_q <= '0;
      clr_busy_q <= 1'b1;
      total_q <= '0;
      ov_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        lo_pt_q[c] <= '0;
        hi_pt_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      clr_busy_q <= clr_busy_d;
      total_q <= total_d;
      ov_q <= ov_d;
      for (int c = 0; c < 3; c++) begin
        lo_pt_q[c] <= lo_pt_d[c];
        hi_pt_q[c] <= hi_pt_d[c];
      end
    end
  end

  assign out_valid_o = ov_q;
  assign red_o = outv_q[0];
  assign green_o = outv_q[1];
  assign blue_o = outv_q[2];
  assign clearing_o = clr_busy_q;

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(outv_q[0])) else $error("result lost");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !q_pop_o) else $error("item taken while clearing");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_cnt_q <= 5'(DivSteps)) else $error("divider overrun");
`endif

endmodule

[src/percentile_contrast_stretch_unit.sv]
// Top level of the percentile contrast stretch unit.
// Depends on pcs_pkg, pcs_queue and pcs_back.
//
//  port group     direction  handshake
//  in_*           input      in_valid_i / in_stall_o
//  out_*          output     out_valid_o / out_stall_i
//  cfg_*          input      cfg_we_i, no wait
//
// A histogram item takes a read and a write of the bin memories in the back.
// A stretch item goes through the bit-serial divider. The last histogram
// item of a frame adds a walk over all bins and a clearing pass. After reset
// a clearing pass runs before any item is taken. A finished result waits in
// the output register.
module percentile_contrast_stretch_unit #(
  parameter int unsigned CountBits = pcs_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [pcs_pkg::PixW-1:0]    red_in_i,
  input  logic [pcs_pkg::PixW-1:0]    green_in_i,
  input  logic [pcs_pkg::PixW-1:0]    blue_in_i,
  input  logic                        frame_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pcs_pkg::PixW-1:0]    red_out_o,
  output logic [pcs_pkg::PixW-1:0]    green_out_o,
  output logic [pcs_pkg::PixW-1:0]    blue_out_o,
  input  logic                        cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pcs_pkg::PctW-1:0]    cfg_data_i
);
  import pcs_pkg::*;

  logic [PctW-1:0] low_pct_q, high_pct_q;
  logic            q_full, q_empty, q_pop, clearing;
  item_t           in_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_pct_q <= PctW'(1);
      high_pct_q <= PctW'(99);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_PCT:  low_pct_q <= cfg_data_i;
        CFG_HIGH_PCT: high_pct_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{op: opcode_i, r: red_in_i, g: green_in_i, b: blue_in_i,
                     fe: frame_end_i};
  assign in_stall_o = q_full;

  pcs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (in_valid_i && !q_full),
    .data_i (in_item),
    .full_o (q_full),
    .pop_i (q_pop),
    .empty_o (q_empty),
    .data_o (q_item)
  );

  pcs_back #(.CountBits(CountBits)) u_back (
    .clk_i, .rst_ni,
    .low_pct_i (low_pct_q),
    .high_pct_i (high_pct_q),
    .q_empty_i (q_empty),
    .q_data_i (q_item),
    .q_pop_o (q_pop),
    .out_valid_o,
    .out_stall_i,
    .red_o (red_out_o),
    .green_o (green_out_o),
    .blue_o (blue_out_o),
    .clearing_o (clearing)
  );

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing && q_full |=> in_stall_o) else $error("stall dropped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("valid dropped");
  a_out_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o)) else $error("data changed");
`endif

endmodule
